// ===== rtl/terminal_line_editor_with_history_top_macros.svh =====
// Assertion macros shared by the line editor RTL.
// Depends on nothing; taken in by `include where checks are written.
`ifndef TERMINAL_LINE_EDITOR_WITH_HISTORY_TOP_MACROS_SVH
`define TERMINAL_LINE_EDITOR_WITH_HISTORY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TLE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line editor check failed");
`define TLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line editor sequencing check failed");
`else
`define TLE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define TLE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/tle_pkg.sv =====
// Package for the terminal line editor: sizes, character codes, sequencer states.
// No dependencies.
package tle_pkg;

   localparam int LINE_LEN_DEF      = 28;
   localparam int HISTORY_DEPTH_DEF = 16;

   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_UP     = 8'h41;
   localparam logic [7:0] CH_DOWN   = 8'h42;
   localparam logic [7:0] CH_RIGHT  = 8'h43;
   localparam logic [7:0] CH_LEFT   = 8'h44;
   localparam logic [7:0] CH_PROMPT = 8'h3E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_K      = 8'h4B;

   localparam logic [1:0] ESC_NORMAL  = 2'd0;
   localparam logic [1:0] ESC_SEEN    = 2'd1;
   localparam logic [1:0] ESC_BRACKET = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLR,
      S_LOAD,
      S_LF,
      S_SUBMIT,
      S_CR,
      S_PROMPT,
      S_BYTES,
      S_SPACE,
      S_BACK,
      S_SAVE,
      S_RIGHT,
      S_LEFT
   } seq_state_type;

endpackage

// ===== rtl/tle_if.sv =====
// Handshake channels of the line editor: received bytes in, emitted bytes out.
// No dependencies.
interface tle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface tle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       to_submit;
   logic       last;
   modport source (output valid, output out_byte, output to_submit, output last, input ready);
   modport sink (input valid, input out_byte, input to_submit, input last, output ready);
endinterface

// ===== rtl/tle_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/terminal_line_editor_with_history_top.sv =====
// Terminal line editor with history: top level with sequencer and edit line.
// Depends on tle_pkg, tle_if, tle_ram and the assertion macro header.
//
// Usage: received terminal bytes arrive on req_ch; every emitted byte leaves on
// rsp_ch with to_submit (part of a submitted line) and last (final byte caused
// by the received byte). Bytes that emit nothing (ESC, the bracket, unknown
// sequences, arrows at a line end) are taken without leaving the idle state.
// One received byte is worked on at a time; req_ch.ready is high only while
// the sequencer is idle. The sequencer emits at most one byte per cycle into a
// single output register, and none while rsp_ch stalls. Insert or delete redraw:
// CR, prompt, the line, a space, then backspaces back to the cursor. Enter:
// LF, the line as submitted bytes, CR and prompt, then a copy of the line into
// the history RAM; submit and copy happen only when the cursor is not at the
// line start. Up/down arrow: ESC [ 2 K, a fetch of the history row, the redraw.
// A stall on rsp_ch holds the sequencer; no byte is lost or repeated.
// Reset empties the edit line and marks every history row as empty (one
// valid flop per row), so no clearing pass is needed after reset.
`include "terminal_line_editor_with_history_top_macros.svh"
module terminal_line_editor_with_history_top #(
   parameter int LINE_LEN      = tle_pkg::LINE_LEN_DEF,
   parameter int HISTORY_DEPTH = tle_pkg::HISTORY_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   tle_req_if.sink   req_ch,
   tle_rsp_if.source rsp_ch
);

   localparam int LW = $clog2(LINE_LEN + 1);
   localparam int CW = $clog2(LINE_LEN + 2);
   localparam int IW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
   localparam int SW = $clog2(HISTORY_DEPTH);
   localparam int HD = HISTORY_DEPTH * LINE_LEN;
   localparam int AW = $clog2(HD);

   tle_pkg::seq_state_type state_ff, state_in;

   logic [1:0]    esc_phase_ff, esc_phase_in;
   logic [7:0]    edit_ff [LINE_LEN];
   logic [7:0]    edit_in [LINE_LEN];
   logic [LW-1:0] cursor_ff, cursor_in;
   logic [LW-1:0] length_ff, length_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] load_slot_ff, load_slot_in;
   logic [HISTORY_DEPTH-1:0] row_valid_ff, row_valid_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          enter_ff, enter_in;
   logic          save_ff, save_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_sub_ff, rsp_sub_in;
   logic       rsp_last_ff, rsp_last_in;

   logic          req_fire;
   logic          emit_ok, emit_req, emit_sub, emit_last, emit_fire;
   logic [7:0]    emit_byte;
   logic [7:0]    c;
   logic [LW-1:0] dcur;
   logic [CW-1:0] back_last;
   logic [SW-1:0] slot_prev, slot_next;

   logic          hist_we, meta_we;
   logic [AW-1:0] hist_waddr, hist_raddr, row_base;
   logic [7:0]    hist_rdata;
   logic [2*LW-1:0] meta_rdata;

   assign req_ch.ready = (state_ff == tle_pkg::S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign c            = req_ch.rx_byte;
   assign emit_ok      = !rsp_valid_ff || rsp_ch.ready;
   assign emit_fire    = emit_req && emit_ok;
   assign dcur         = cursor_ff - LW'(1);
   assign back_last    = CW'(length_ff) - CW'(cursor_ff);
   assign slot_prev    = (slot_ff == '0) ? SW'(HISTORY_DEPTH - 1) : slot_ff - SW'(1);
   assign slot_next    = (slot_ff == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + SW'(1);

   // same base serves load (load_slot) and save (slot)
   assign row_base   = (state_ff == tle_pkg::S_SAVE) ?
                       AW'(slot_ff) * AW'(LINE_LEN) : AW'(load_slot_ff) * AW'(LINE_LEN);
   assign hist_we    = (state_ff == tle_pkg::S_SAVE);
   assign hist_waddr = row_base + AW'(idx_ff);
   assign hist_raddr = row_base + AW'(idx_ff);
   assign meta_we    = hist_we && (idx_ff == CW'(LINE_LEN - 1));

   tle_ram #(.WIDTH(8), .DEPTH(HD)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (edit_ff[idx_ff[IW-1:0]]),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   tle_ram #(.WIDTH(2 * LW), .DEPTH(HISTORY_DEPTH)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (slot_ff),
      .wr_data ({cursor_ff, length_ff}),
      .rd_addr (load_slot_ff),
      .rd_data (meta_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      esc_phase_in = esc_phase_ff;
      edit_in      = edit_ff;
      cursor_in    = cursor_ff;
      length_in    = length_ff;
      slot_in      = slot_ff;
      load_slot_in = load_slot_ff;
      row_valid_in = row_valid_ff;
      idx_in       = idx_ff;
      enter_in     = enter_ff;
      save_in      = save_ff;
      emit_req     = 1'b0;
      emit_byte    = tle_pkg::CH_BS;
      emit_sub     = 1'b0;
      emit_last    = 1'b0;

      case (state_ff)
         tle_pkg::S_IDLE: begin
            if (req_fire) begin
               case (esc_phase_ff)
                  tle_pkg::ESC_NORMAL: begin
                     if (c == tle_pkg::CH_ESC) begin
                        esc_phase_in = tle_pkg::ESC_SEEN;
                     end else if (c == tle_pkg::CH_CR) begin
                        enter_in = 1'b1;
                        save_in  = (cursor_ff != '0);
                        state_in = tle_pkg::S_LF;
                     end else if (c == tle_pkg::CH_DEL) begin
                        if (cursor_ff != '0 && length_ff != '0) begin
                           cursor_in = dcur;
                           length_in = length_ff - LW'(1);
                           for (int i = 0; i < LINE_LEN - 1; i++) begin
                              if (LW'(i) >= dcur && LW'(i) < length_ff - LW'(1)) begin
                                 edit_in[i] = edit_ff[i + 1];
                              end
                           end
                        end
                        enter_in = 1'b0;
                        state_in = tle_pkg::S_CR;
                     end else begin
                        if (length_ff < LW'(LINE_LEN)) begin
                           for (int i = 1; i < LINE_LEN; i++) begin
                              if (LW'(i) > cursor_ff && LW'(i) <= length_ff) begin
                                 edit_in[i] = edit_ff[i - 1];
                              end
                           end
                           edit_in[cursor_ff[IW-1:0]] = c;
                           cursor_in = cursor_ff + LW'(1);
                           length_in = length_ff + LW'(1);
                        end
                        enter_in = 1'b0;
                        state_in = tle_pkg::S_CR;
                     end
                  end
                  tle_pkg::ESC_SEEN: begin
                     esc_phase_in = (c == tle_pkg::CH_LBRK) ?
                                    tle_pkg::ESC_BRACKET : tle_pkg::ESC_NORMAL;
                  end
                  default: begin
                     // after ESC [ (the unused phase behaves the same)
                     esc_phase_in = tle_pkg::ESC_NORMAL;
                     idx_in       = '0;
                     if (c == tle_pkg::CH_UP) begin
                        slot_in      = slot_prev;
                        load_slot_in = slot_prev;
                        state_in     = tle_pkg::S_CLR;
                     end else if (c == tle_pkg::CH_DOWN) begin
                        slot_in      = slot_next;
                        load_slot_in = slot_ff;
                        state_in     = tle_pkg::S_CLR;
                     end else if (c == tle_pkg::CH_RIGHT) begin
                        if (cursor_ff < length_ff) begin
                           cursor_in = cursor_ff + LW'(1);
                           state_in  = tle_pkg::S_RIGHT;
                        end
                     end else if (c == tle_pkg::CH_LEFT) begin
                        if (cursor_ff != '0) begin
                           cursor_in = dcur;
                           state_in  = tle_pkg::S_LEFT;
                        end
                     end
                  end
               endcase
            end
         end
         tle_pkg::S_CLR: begin
            emit_req = 1'b1;
            case (idx_ff[1:0])
               2'd0:    emit_byte = tle_pkg::CH_ESC;
               2'd1:    emit_byte = tle_pkg::CH_LBRK;
               2'd2:    emit_byte = tle_pkg::CH_TWO;
               default: emit_byte = tle_pkg::CH_K;
            endcase
            if (emit_ok) begin
               if (idx_ff == CW'(3)) begin
                  idx_in   = '0;
                  state_in = tle_pkg::S_LOAD;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         tle_pkg::S_LOAD: begin
            // read data is registered and belongs to the address of the cycle before
            if (idx_ff != '0) begin
               edit_in[IW'(idx_ff - CW'(1))] =
                  row_valid_ff[load_slot_ff] ? hist_rdata : 8'h00;
            end
            if (idx_ff == CW'(1)) begin
               cursor_in = row_valid_ff[load_slot_ff] ? meta_rdata[2*LW-1:LW] : '0;
               length_in = row_valid_ff[load_slot_ff] ? meta_rdata[LW-1:0] : '0;
            end
            if (idx_ff == CW'(LINE_LEN)) begin
               enter_in = 1'b0;
               state_in = tle_pkg::S_CR;
            end
            idx_in = idx_ff + CW'(1);
         end
         tle_pkg::S_LF: begin
            emit_req  = 1'b1;
            emit_byte = tle_pkg::CH_LF;
            if (emit_ok) begin
               idx_in   = '0;
               state_in = save_ff ? tle_pkg::S_SUBMIT : tle_pkg::S_CR;
            end
         end
         tle_pkg::S_SUBMIT: begin
            emit_req  = 1'b1;
            emit_byte = edit_ff[idx_ff[IW-1:0]];
            emit_sub  = 1'b1;
            if (emit_ok) begin
               idx_in = idx_ff + CW'(1);
               if (idx_ff == CW'(length_ff) - CW'(1)) begin
                  state_in = tle_pkg::S_CR;
               end
            end
         end
         tle_pkg::S_CR: begin
            emit_req  = 1'b1;
            emit_byte = tle_pkg::CH_CR;
            if (emit_ok) begin
               state_in = tle_pkg::S_PROMPT;
            end
         end
         tle_pkg::S_PROMPT: begin
            emit_req  = 1'b1;
            emit_byte = tle_pkg::CH_PROMPT;
            emit_last = enter_ff;
            if (emit_ok) begin
               idx_in = '0;
               if (enter_ff) begin
                  state_in = save_ff ? tle_pkg::S_SAVE : tle_pkg::S_IDLE;
               end else begin
                  state_in = (length_ff == '0) ? tle_pkg::S_SPACE : tle_pkg::S_BYTES;
               end
            end
         end
         tle_pkg::S_BYTES: begin
            emit_req  = 1'b1;
            emit_byte = edit_ff[idx_ff[IW-1:0]];
            if (emit_ok) begin
               idx_in = idx_ff + CW'(1);
               if (idx_ff == CW'(length_ff) - CW'(1)) begin
                  state_in = tle_pkg::S_SPACE;
               end
            end
         end
         tle_pkg::S_SPACE: begin
            emit_req  = 1'b1;
            emit_byte = tle_pkg::CH_SPACE;
            if (emit_ok) begin
               idx_in   = '0;
               state_in = tle_pkg::S_BACK;
            end
         end
         tle_pkg::S_BACK: begin
            emit_req  = 1'b1;
            emit_byte = tle_pkg::CH_BS;
            emit_last = (idx_ff == back_last);
            if (emit_ok) begin
               idx_in = idx_ff + CW'(1);
               if (idx_ff == back_last) begin
                  state_in = tle_pkg::S_IDLE;
               end
            end
         end
         tle_pkg::S_SAVE: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(LINE_LEN - 1)) begin
               row_valid_in[slot_ff]   = 1'b1;
               row_valid_in[slot_next] = 1'b0;
               slot_in   = slot_next;
               cursor_in = '0;
               length_in = '0;
               state_in  = tle_pkg::S_IDLE;
            end
         end
         tle_pkg::S_RIGHT: begin
            emit_req = 1'b1;
            case (idx_ff[1:0])
               2'd0:    emit_byte = tle_pkg::CH_ESC;
               2'd1:    emit_byte = tle_pkg::CH_LBRK;
               default: emit_byte = tle_pkg::CH_RIGHT;
            endcase
            emit_last = (idx_ff == CW'(2));
            if (emit_ok) begin
               idx_in = idx_ff + CW'(1);
               if (idx_ff == CW'(2)) begin
                  state_in = tle_pkg::S_IDLE;
               end
            end
         end
         tle_pkg::S_LEFT: begin
            emit_req  = 1'b1;
            emit_byte = tle_pkg::CH_BS;
            emit_last = 1'b1;
            if (emit_ok) begin
               state_in = tle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tle_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_sub_in   = rsp_sub_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_sub_in   = emit_sub;
         rsp_last_in  = emit_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tle_pkg::S_IDLE;
         esc_phase_ff <= tle_pkg::ESC_NORMAL;
         cursor_ff    <= '0;
         length_ff    <= '0;
         slot_ff      <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         esc_phase_ff <= esc_phase_in;
         cursor_ff    <= cursor_in;
         length_ff    <= length_in;
         slot_ff      <= slot_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edit_ff      <= edit_in;
      load_slot_ff <= load_slot_in;
      idx_ff       <= idx_in;
      enter_ff     <= enter_in;
      save_ff      <= save_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_sub_ff   <= rsp_sub_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_byte  = rsp_byte_ff;
   assign rsp_ch.to_submit = rsp_sub_ff;
   assign rsp_ch.last      = rsp_last_ff;

   `TLE_ASSERT_NOW(a_cursor_in_line, clock, reset, 1'b1, cursor_ff <= length_ff)
   `TLE_ASSERT_NOW(a_length_cap, clock, reset, 1'b1, length_ff <= LW'(LINE_LEN))
   `TLE_ASSERT_NEXT(a_last_ends_item, clock, reset, emit_fire && emit_last,
      state_ff == tle_pkg::S_IDLE || state_ff == tle_pkg::S_SAVE)
   `TLE_ASSERT_NOW(a_submit_only_in_line, clock, reset, emit_fire && emit_sub,
      state_ff == tle_pkg::S_SUBMIT)

endmodule
